>>> hw/rtl/ssd_pkg.sv
// Shared constants, register indexes and controller/datapath link types
// for the smoothed score detector. No dependencies.
`default_nettype none
package ssd_pkg;

  // Default sizing, handed to the top level as parameter defaults
  localparam int MAX_WINDOW_DEF = 64;
  localparam int SCORE_BITS_DEF = 16;

  // Fixed register field widths
  localparam int WLEN_W    = 7;
  localparam int CD_W      = 16;
  localparam int CFG_IDX_W = 2;

  // Register reset values (threshold reset is one half, derived from the score width)
  localparam int WLEN_RST     = 5;
  localparam int COOLDOWN_RST = 1000;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COOLDOWN  = 2'd2;

  // Controller to datapath
  typedef struct packed {
    logic accept_score;  // latch score, issue window read
    logic accept_tick;   // advance the tick counter
    logic update;        // update window and sum, load divider
    logic div_step;      // one quotient bit
    logic load_out;      // evaluate detection, load result item
  } ssd_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic div_last;      // current divider step is the final one
  } ssd_stat_t;

endpackage
`default_nettype wire

>>> hw/rtl/ssd_if.sv
// Valid/ready channel interfaces for input items and result items.
// Depends on ssd_pkg for the default score width.
`default_nettype none
interface ssd_in_if import ssd_pkg::*; #(
  parameter int SCORE_BITS = SCORE_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic                  kind;
  logic [SCORE_BITS-1:0] score;

  modport source (output valid, output kind, output score, input ready);
  modport sink   (input valid, input kind, input score, output ready);
endinterface

interface ssd_out_if import ssd_pkg::*; #(
  parameter int SCORE_BITS = SCORE_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic                  detected;
  logic [SCORE_BITS-1:0] raw_score;
  logic [SCORE_BITS-1:0] smoothed_score;

  modport source (output valid, output detected, output raw_score,
                  output smoothed_score, input ready);
  modport sink   (input valid, input detected, input raw_score,
                  input smoothed_score, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/ssd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module ssd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output      logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/ssd_ctrl.sv
// Controller for the smoothed score detector: sequences accept, window
// update, serial division and result hand-off. Depends on ssd_pkg.
`default_nettype none
module ssd_ctrl import ssd_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  input  wire logic      in_kind,
  input  wire logic      out_ready,
  input  wire ssd_stat_t stat,
  output      logic      in_ready,
  output      logic      out_valid,
  output      ssd_cmd_t  cmd
);

  typedef enum logic [1:0] {S_IDLE, S_READ, S_DIV, S_FINISH} state_t;

  state_t state_r;
  logic   in_ready_r;
  logic   out_valid_r;
  logic   in_fire;
  logic   out_free;

  assign in_fire  = (state_r == S_IDLE) && in_valid && in_ready_r;
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    cmd              = '0;
    cmd.accept_score = in_fire && !in_kind;
    cmd.accept_tick  = in_fire && in_kind;
    cmd.update       = (state_r == S_READ);
    cmd.div_step     = (state_r == S_DIV);
    cmd.load_out     = (state_r == S_FINISH) && out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      in_ready_r  <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      // drop the result once taken, unless a new one replaces it
      if (out_valid_r && out_ready && !cmd.load_out) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_fire && !in_kind) begin
            state_r    <= S_READ;
            in_ready_r <= 1'b0;
          end
        end
        S_READ: begin
          state_r <= S_DIV;
        end
        S_DIV: begin
          if (stat.div_last) begin
            state_r <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            in_ready_r  <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r    <= S_IDLE;
          in_ready_r <= 1'b1;
        end
      endcase
    end
  end

  assign in_ready  = in_ready_r;
  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

>>> hw/rtl/ssd_dp.sv
// Datapath: configuration registers, window store, running sum, serial
// restoring divider, tick counter and result registers.
// Depends on ssd_pkg and ssd_ram.
`default_nettype none
module ssd_dp import ssd_pkg::*; #(
  parameter int MAX_WINDOW = MAX_WINDOW_DEF,
  parameter int SCORE_BITS = SCORE_BITS_DEF,
  parameter int CFG_W      = 17
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire ssd_cmd_t              cmd,
  output      ssd_stat_t             stat,
  input  wire logic [SCORE_BITS-1:0] in_score,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_W-1:0]      cfg_data,
  output      logic                  out_detected,
  output      logic [SCORE_BITS-1:0] out_raw_score,
  output      logic [SCORE_BITS-1:0] out_smoothed_score
);

  localparam int POS_W   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int LEN_W   = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W   = SCORE_BITS + LEN_W;
  localparam int DCNT_W  = $clog2(SUM_W);
  localparam int THR_W   = SCORE_BITS + 1;

  localparam logic [DCNT_W-1:0] DIV_LAST = DCNT_W'(SUM_W - 1);
  localparam logic [THR_W-1:0]  THR_RST  = THR_W'(1) << (SCORE_BITS - 1);

  // Configuration
  logic [THR_W-1:0]  thresh_r;
  logic [WLEN_W-1:0] wlen_r;
  logic [CD_W-1:0]   cool_r;

  // Window state
  logic [MAX_WINDOW-1:0] valid_r;
  logic [POS_W-1:0]      wpos_r;
  logic [SUM_W-1:0]      sum_r;
  logic [CD_W-1:0]       ticks_r;

  // Per-item working registers
  logic [SCORE_BITS-1:0] score_r;
  logic [POS_W-1:0]      pos_r;
  logic [LEN_W-1:0]      len_r;
  logic [SUM_W-1:0]      quot_r;
  logic [LEN_W-1:0]      rem_r;
  logic [DCNT_W-1:0]     div_cnt_r;

  logic [LEN_W-1:0]      eff_len;
  logic [POS_W-1:0]      pos_sel;
  logic [SCORE_BITS-1:0] rd_data;
  logic [SCORE_BITS-1:0] old_score;
  logic [SUM_W-1:0]      sum_nxt;
  logic [LEN_W-1:0]      pos_inc;
  logic [POS_W-1:0]      wpos_nxt;
  logic [LEN_W:0]        trial;
  logic [LEN_W:0]        diff;
  logic                  ge;
  logic [SCORE_BITS-1:0] avg;
  logic                  det;
  logic                  wlen_wr;

  // Window length: zero acts as one, above capacity acts as capacity
  always_comb begin
    if (wlen_r == '0) begin
      eff_len = LEN_W'(1);
    end else if (32'(wlen_r) > 32'(MAX_WINDOW)) begin
      eff_len = LEN_W'(MAX_WINDOW);
    end else begin
      eff_len = LEN_W'(wlen_r);
    end
  end

  assign pos_sel = (LEN_W'(wpos_r) >= eff_len) ? '0 : wpos_r;

  ssd_ram #(
    .WIDTH (SCORE_BITS),
    .DEPTH (MAX_WINDOW),
    .AW    (POS_W)
  ) u_win (
    .clk   (clk),
    .we    (cmd.update),
    .waddr (pos_r),
    .wdata (score_r),
    .re    (cmd.accept_score),
    .raddr (pos_sel),
    .rdata (rd_data)
  );

  // Entries never written since the last clear read as zero
  assign old_score = valid_r[pos_r] ? rd_data : '0;
  assign sum_nxt   = sum_r - SUM_W'(old_score) + SUM_W'(score_r);
  assign pos_inc   = LEN_W'(pos_r) + LEN_W'(1);
  assign wpos_nxt  = (pos_inc >= len_r) ? '0 : POS_W'(pos_inc);

  // One restoring step
  assign trial = {rem_r, quot_r[SUM_W-1]};
  assign ge    = trial >= {1'b0, len_r};
  assign diff  = trial - {1'b0, len_r};

  assign avg = quot_r[SCORE_BITS-1:0];
  assign det = ({1'b0, avg} > thresh_r) && (ticks_r >= cool_r);

  assign wlen_wr       = cfg_we && (cfg_index == REG_WINDOW);
  assign stat.div_last = cmd.div_step && (div_cnt_r == DIV_LAST);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= THR_RST;
      wlen_r   <= WLEN_W'(WLEN_RST);
      cool_r   <= CD_W'(COOLDOWN_RST);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_THRESHOLD: thresh_r <= cfg_data[THR_W-1:0];
        REG_WINDOW:    wlen_r   <= cfg_data[WLEN_W-1:0];
        REG_COOLDOWN:  cool_r   <= cfg_data[CD_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Window bookkeeping
  always_ff @(posedge clk) begin
    if (!rst_n || wlen_wr) begin
      valid_r <= '0;
      wpos_r  <= '0;
      sum_r   <= '0;
    end else if (cmd.update) begin
      valid_r[pos_r] <= 1'b1;
      wpos_r         <= wpos_nxt;
      sum_r          <= sum_nxt;
    end
  end

  // Tick counter, saturating at the cooldown
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ticks_r <= CD_W'(COOLDOWN_RST);
    end else if (cmd.accept_tick) begin
      if (ticks_r < cool_r) begin
        ticks_r <= ticks_r + CD_W'(1);
      end else begin
        ticks_r <= cool_r;
      end
    end else if (cmd.load_out && det) begin
      ticks_r <= '0;
    end
  end

  // Item registers and divider
  always_ff @(posedge clk) begin
    if (cmd.accept_score) begin
      score_r <= in_score;
      pos_r   <= pos_sel;
      len_r   <= eff_len;
    end
    if (cmd.update) begin
      quot_r    <= sum_nxt;
      rem_r     <= '0;
      div_cnt_r <= '0;
    end else if (cmd.div_step) begin
      quot_r    <= {quot_r[SUM_W-2:0], ge};
      rem_r     <= ge ? diff[LEN_W-1:0] : trial[LEN_W-1:0];
      div_cnt_r <= div_cnt_r + DCNT_W'(1);
    end
    if (cmd.load_out) begin
      out_detected       <= det;
      out_raw_score      <= score_r;
      out_smoothed_score <= avg;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/smoothed_score_detector.sv
// A score item is accepted, then the window and sum are updated, the serial
// divider forms the average (one quotient bit a cycle) and the result item is
// loaded; only then is the next item taken. Tick items advance the tick counter
// and give no result. A waiting result does not block acceptance of the next
// item. Synchronous active-low reset; no clearing pass.
//
// Top level of the smoothed score detector. Depends on ssd_pkg, ssd_if,
// ssd_ctrl, ssd_dp and ssd_ram.
`default_nettype none
module smoothed_score_detector import ssd_pkg::*; #(
  parameter int MAX_WINDOW = MAX_WINDOW_DEF,
  parameter int SCORE_BITS = SCORE_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  ssd_in_if.sink                     in_ch,
  ssd_out_if.source                  out_ch,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [((SCORE_BITS + 1 > CD_W) ? SCORE_BITS + 1 : CD_W)-1:0] cfg_data
);

  // Configuration data is as wide as the widest register: the threshold
  // (one bit over the score, so it can hold 1.0) or the cooldown.
  localparam int CFG_W = (SCORE_BITS + 1 > CD_W) ? SCORE_BITS + 1 : CD_W;

  ssd_cmd_t  cmd;
  ssd_stat_t stat;

  // Controller: owns the handshake flags and sequencing. The input side is
  // ready again as soon as a result has been parked in the output register,
  // so a slow consumer only stalls us once a second result is finished.
  ssd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_kind   (in_ch.kind),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .cmd       (cmd)
  );

  // Datapath: window store with per-entry valid bits (cleared at reset and
  // on a window length write), running sum, restoring divider for the
  // average, tick counter and the result registers.
  ssd_dp #(
    .MAX_WINDOW (MAX_WINDOW),
    .SCORE_BITS (SCORE_BITS),
    .CFG_W      (CFG_W)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .in_score           (in_ch.score),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .out_detected       (out_ch.detected),
    .out_raw_score      (out_ch.raw_score),
    .out_smoothed_score (out_ch.smoothed_score)
  );

endmodule
`default_nettype wire

>>> hw/rtl/ssd_checker.sv
// Port-level checker for the smoothed score detector, bound to the top level.
// Depends on ssd_pkg.
`default_nettype none
module ssd_checker import ssd_pkg::*; #(
  parameter int SCORE_BITS = SCORE_BITS_DEF
) (
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  in_valid,
  input wire logic                  in_ready,
  input wire logic                  in_kind,
  input wire logic                  out_valid,
  input wire logic                  out_ready,
  input wire logic                  out_detected,
  input wire logic [SCORE_BITS-1:0] out_raw_score,
  input wire logic [SCORE_BITS-1:0] out_smoothed_score
);

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_detected) &&
    $stable(out_raw_score) && $stable(out_smoothed_score))
    else $error("result changed while stalled");

  // No result straight out of reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // A score occupies the block: no new item in the next cycle
  a_score_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !in_kind |=> !in_ready)
    else $error("item accepted while a score is in progress");

  // A tick never raises a result
  a_tick_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_kind && !out_valid |=> !out_valid)
    else $error("tick produced a result");

  // A detection needs a smoothed score above the threshold, hence nonzero
  a_det_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_detected |-> out_smoothed_score != '0)
    else $error("detection with zero smoothed score");

endmodule

bind smoothed_score_detector ssd_checker #(
  .SCORE_BITS (SCORE_BITS)
) u_ssd_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_ch.valid),
  .in_ready           (in_ch.ready),
  .in_kind            (in_ch.kind),
  .out_valid          (out_ch.valid),
  .out_ready          (out_ch.ready),
  .out_detected       (out_ch.detected),
  .out_raw_score      (out_ch.raw_score),
  .out_smoothed_score (out_ch.smoothed_score)
);
`default_nettype wire
